// ----- sv/slle_pkg.sv -----
// shared types and constants for the sorted list engine
// no dependencies; imported by every module of the block
package slle_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int FIELD_W = 5;
	localparam int VAL_W   = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_COUNT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} st_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_UPDATE
	} state_t;

	typedef struct packed {
		logic capture;
		logic compare;
		logic commit;
	} dp_cmd_t;

	// low result bits of a count, zero-extended when the count is narrower
	function automatic logic [FIELD_W-1:0] fit_field(input logic [CNT_W-1:0] v);
		logic [CNT_W+FIELD_W-1:0] w;
		w = {{FIELD_W{1'b0}}, v};
		return w[FIELD_W-1:0];
	endfunction

endpackage

// ----- sv/slle_ctrl.sv -----
// controller state machine for the sorted list engine
// depends on slle_pkg; drives datapath commands and both handshakes
module slle_ctrl import slle_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_COMPARE;
			end
			S_COMPARE: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (!out_valid_q || !out_stall) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			S_COMPARE: begin
				cmd.compare = 1'b1;
			end
			S_UPDATE: begin
				cmd.commit = !out_valid_q || !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_accept_to_compare: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_COMPARE))
		else $error("accepted item did not enter compare");
	a_compare_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMPARE) |=> (state_q == S_UPDATE))
		else $error("compare not followed by update");
	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed result not presented");
`endif

endmodule

// ----- sv/slle_dp.sv -----
// datapath for the sorted list engine: row of entry cells, compare and shift
// depends on slle_pkg; steered by the command struct from slle_ctrl
module slle_dp import slle_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic [1:0]         opcode,
	input  logic [VAL_W-1:0]   value,
	output logic [1:0]         status,
	output logic [FIELD_W-1:0] position,
	output logic [FIELD_W-1:0] entry_count
);

	logic [VAL_W-1:0]   entry_q [DEPTH];
	logic [CNT_W-1:0]   occ_q;
	op_t                op_q;
	logic [VAL_W-1:0]   key_q;
	logic [DEPTH-1:0]   lt_s1;
	logic [DEPTH-1:0]   le_s1;
	logic [DEPTH-1:0]   eq_s1;
	logic [DEPTH-1:0]   eq_first;
	logic               found;
	logic [CNT_W-1:0]   found_idx;
	logic               full;
	logic               empty;
	logic               do_insert;
	logic               do_delete;
	st_t                st_d;
	logic [CNT_W-1:0]   pos_d;
	logic [CNT_W-1:0]   occ_d;
	logic [1:0]         status_q;
	logic [FIELD_W-1:0] position_q;
	logic [FIELD_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(opcode);
			key_q <= value;
		end
	end

	// parallel compare of every occupied cell against the key
	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < DEPTH; i++) begin
				lt_s1[i] <= (CNT_W'(i) < occ_q) && ($signed(entry_q[i]) < $signed(key_q));
				le_s1[i] <= (CNT_W'(i) < occ_q) && ($signed(entry_q[i]) <= $signed(key_q));
				eq_s1[i] <= (CNT_W'(i) < occ_q) && (entry_q[i] == key_q);
			end
		end
	end

	// first match: equal here and either this is cell 0 or the cell before holds a smaller value
	always_comb begin
		found_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			eq_first[i] = eq_s1[i] && ((i == 0) ? 1'b1 : lt_s1[(i == 0) ? 0 : i - 1]);
			if (eq_first[i]) found_idx = found_idx | CNT_W'(i);
		end
		found = |eq_first;
	end

	assign full  = (occ_q == CNT_W'(DEPTH));
	assign empty = (occ_q == '0);

	always_comb begin
		st_d      = ST_OK;
		pos_d     = '0;
		occ_d     = occ_q;
		do_insert = 1'b0;
		do_delete = 1'b0;
		case (op_q)
			OP_INSERT: begin
				if (full) st_d = ST_FULL;
				else begin
					do_insert = 1'b1;
					occ_d     = occ_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (empty) st_d = ST_EMPTY;
				else if (!found) st_d = ST_NOT_FOUND;
				else begin
					do_delete = 1'b1;
					occ_d     = occ_q - CNT_W'(1);
				end
			end
			OP_SEARCH: begin
				if (!found) st_d = ST_NOT_FOUND;
				else pos_d = found_idx + CNT_W'(1);
			end
			OP_COUNT: begin
				st_d = ST_OK;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	// each cell keeps, takes the key, or takes a neighbour
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.commit && do_insert && !le_s1[g]) begin
				if (g == 0) entry_q[g] <= key_q;
				else if (le_s1[(g == 0) ? 0 : g - 1]) entry_q[g] <= key_q;
				else entry_q[g] <= entry_q[(g == 0) ? 0 : g - 1];
			end else if (cmd.commit && do_delete && !lt_s1[g] && (g < DEPTH - 1)) begin
				entry_q[g] <= entry_q[(g < DEPTH - 1) ? g + 1 : g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.commit) begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q   <= st_d;
			position_q <= fit_field(pos_d);
			count_q    <= fit_field(occ_d);
		end
	end

	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = count_q;

`ifndef NO_ASSERTIONS
	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy beyond table depth");
	a_occ_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(occ_q))
		else $error("occupancy changed outside commit");
	a_single_first_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $onehot0(eq_first))
		else $error("more than one first match");
`endif

endmodule

// ----- sv/sorted_list_engine_core.sv -----
// top level of the sorted list engine
// depends on slle_pkg, slle_ctrl and slle_dp
//
// ordered table of up to DEPTH signed 32-bit values, kept ascending in a row of
// register cells. every transfer in gives exactly one transfer out: insert places
// the value after any equal ones (dropped with status full when the table is
// full), delete removes the first equal value, search returns its 1-based
// position, count only reports; each result carries the count after the
// operation. an item is captured at its transfer in, then all cells compare
// against the key at once, then the cells shift in place and the result
// register loads; a new item is taken only after the last one has been
// committed. the input stalls while an item is in flight; a finished result
// sits in the output register and does not hold off the next transfer in,
// but that item's update waits until the earlier result has been taken.
// table contents are not cleared at reset, only the count, so no start-up
// pass is needed
module sorted_list_engine_core import slle_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [VAL_W-1:0]   value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [FIELD_W-1:0] position,
	output logic [FIELD_W-1:0] entry_count
);

	// command bundle from the sequencer into the cell row
	dp_cmd_t cmd;

	// sequencer: capture, compare, commit, plus the output valid flag
	slle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// cell row, compare vectors, occupancy and result registers
	slle_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (opcode),
		.value       (value),
		.status      (status),
		.position    (position),
		.entry_count (entry_count)
	);

endmodule

// ----- tb/tb_top.sv -----
// self-checking bench for sorted_list_engine_core: ordered-table shadow class, drivers, monitor
// depends on slle_pkg and the sorted_list_engine_core rtl

module tb_top;
	import slle_pkg::*;

	// one expected result per transfer in
	typedef struct packed {
		st_t              status;
		logic [FIELD_W-1:0] position;
		logic [FIELD_W-1:0] entry_count;
	} outcome_t;

	// ascending table of signed values, mirrored beside the block
	class sorted_table_shadow;
		logic signed [VAL_W-1:0] cells [DEPTH];
		int unsigned             fill;
		outcome_t                awaited[$];

		// index of the first stored value equal to v, or fill when absent
		function int unsigned first_equal(logic signed [VAL_W-1:0] v);
			for (int unsigned i = 0; i < fill; i++) begin
				if (cells[i] == v)
					return i;
				if (cells[i] > v)
					break;
			end
			return fill;
		endfunction

		// update the table for one accepted transfer and queue its outcome
		function void apply_item(op_t op, logic signed [VAL_W-1:0] v);
			outcome_t    o;
			int unsigned idx;
			o.status   = ST_OK;
			o.position = '0;
			case (op)
				OP_INSERT: begin
					if (fill >= DEPTH)
						o.status = ST_FULL;
					else begin
						// new value goes after every equal one
						idx = 0;
						while (idx < fill && cells[idx] <= v)
							idx++;
						for (int unsigned i = fill; i > idx; i--)
							cells[i] = cells[i-1];
						cells[idx] = v;
						fill++;
					end
				end
				OP_DELETE: begin
					if (fill == 0)
						o.status = ST_EMPTY;
					else begin
						idx = first_equal(v);
						if (idx >= fill)
							o.status = ST_NOT_FOUND;
						else begin
							for (int unsigned i = idx; i + 1 < fill; i++)
								cells[i] = cells[i+1];
							fill--;
						end
					end
				end
				OP_SEARCH: begin
					idx = first_equal(v);
					if (idx >= fill)
						o.status = ST_NOT_FOUND;
					else
						o.position = FIELD_W'(idx + 1);
				end
				default: ;
			endcase
			o.entry_count = FIELD_W'(fill);
			awaited.push_back(o);
		endfunction

		// compare one result with the oldest outcome; empty string when it matches
		function string check_result(logic [1:0] st, logic [FIELD_W-1:0] pos,
				logic [FIELD_W-1:0] cnt);
			outcome_t o;
			string    msg;
			if (awaited.size() == 0)
				return $sformatf("result with nothing awaited: status %0d position %0d count %0d",
					st, pos, cnt);
			o   = awaited.pop_front();
			msg = "";
			if (st !== o.status)
				msg = {msg, $sformatf(" status got %0d want %0d", st, o.status)};
			if (pos !== o.position)
				msg = {msg, $sformatf(" position got %0d want %0d", pos, o.position)};
			if (cnt !== o.entry_count)
				msg = {msg, $sformatf(" entry_count got %0d want %0d", cnt, o.entry_count)};
			if (msg != "")
				msg = {"result field wrong:", msg};
			return msg;
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = 2'd0;
	logic [VAL_W-1:0]   value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [FIELD_W-1:0] position;
	logic [FIELD_W-1:0] entry_count;

	sorted_table_shadow shadow = new;
	int unsigned        fail_count = 0;
	bit                 rx_random = 1'b0;   // receiver stalls at random when set
	int unsigned        rx_hold_cycles = 0; // one long receiver hold-off, in cycles

	sorted_list_engine_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.position    (position),
		.entry_count (entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// generous ceiling well above the slowest correct run
	initial begin
		#6000000;
		$display("** sorted_list_engine_core: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(input bit active);
		int unsigned r;
		if (!active)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// growing phases favour insert, shrinking ones favour delete
	function automatic op_t pick_op(input bit grow);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < (grow ? 55 : 20))
			return OP_INSERT;
		if (r < (grow ? 72 : 65))
			return OP_DELETE;
		if (r < 90)
			return OP_SEARCH;
		return OP_COUNT;
	endfunction

	// values cluster so that equal keys, hits and extremes are frequent
	function automatic logic [VAL_W-1:0] pick_value(input op_t op);
		int unsigned r;
		int          s;
		r = $urandom_range(0, 99);
		if (op != OP_INSERT && shadow.fill != 0 && r < 60)
			return shadow.cells[$urandom_range(0, shadow.fill - 1)];
		r = $urandom_range(0, 99);
		if (r < 50) begin
			s = $urandom_range(0, 8);
			return VAL_W'(s - 4);
		end
		if (r < 62) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h8000_0001;
				2: return 32'h7FFF_FFFE;
				default: return 32'h7FFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	// offer one item after the requested idle gap and hold it until the transfer
	task automatic offer_item(input op_t op, input logic [VAL_W-1:0] v,
			input int unsigned gap);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
			opcode   = 2'($urandom_range(0, 3));
			value    = $urandom;
		end
		@(negedge clk);
		in_valid = 1'b1;
		opcode   = op;
		value    = v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		shadow.apply_item(op, v);
	endtask

	// sender pause until every awaited result has been taken or the limit runs out
	task automatic drain_results(input int unsigned limit);
		int unsigned waited;
		waited = 0;
		while (shadow.awaited.size() != 0 && waited < limit) begin
			@(negedge clk);
			in_valid = 1'b0;
			waited++;
		end
	endtask

	// receiver: random stalls, or one long hold-off counted here on request
	initial begin : receiver
		int unsigned n;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles != 0) begin
				n              = rx_hold_cycles;
				rx_hold_cycles = 0;
				out_stall      = 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				n         = pick_gap(rx_random);
				out_stall = (n != 0);
				if (n > 1)
					repeat (n - 1) @(negedge clk);
			end
		end
	end

	// result transfers are checked at the rising edge they happen on
	always @(posedge clk) begin : result_monitor
		string msg;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			msg = shadow.check_result(status, position, entry_count);
			if (msg != "")
				report_mismatch(msg);
		end
	end

	initial begin : stimulus
		op_t op;
		bit  grow;
		bit  tx_idle;

		repeat (12) @(negedge clk);
		arst_n    = 1'b1;
		rx_random = 1'b1;

		// empty table: count, search miss, delete reports empty
		offer_item(OP_COUNT, 32'h0000_0000, pick_gap(1));
		offer_item(OP_SEARCH, 32'h0000_0005, pick_gap(1));
		offer_item(OP_DELETE, 32'h0000_0005, pick_gap(1));
		// extremes, a duplicate and a negative
		offer_item(OP_INSERT, 32'h8000_0000, pick_gap(1));
		offer_item(OP_INSERT, 32'h7FFF_FFFF, pick_gap(1));
		offer_item(OP_INSERT, 32'h0000_0000, pick_gap(1));
		offer_item(OP_INSERT, 32'h0000_0000, pick_gap(1));
		offer_item(OP_INSERT, 32'hFFFF_FFFF, pick_gap(1));
		// hit at the head, first of two equal values
		offer_item(OP_SEARCH, 32'h8000_0000, pick_gap(1));
		offer_item(OP_SEARCH, 32'h0000_0000, pick_gap(1));
		// absent delete, then delete of the first equal value
		offer_item(OP_DELETE, 32'h0000_0007, pick_gap(1));
		offer_item(OP_DELETE, 32'h0000_0000, pick_gap(1));
		// fill to the brim, then one insert that gets dropped
		for (int i = 0; i < 13; i++)
			offer_item(OP_INSERT, pick_value(OP_INSERT), pick_gap(1));

		for (int p = 0; p < 10; p++) begin
			grow      = (p % 2 == 0) || (p == 3);
			tx_idle   = (p != 0) && (p != 4) && (p != 7);
			rx_random = (p != 0) && (p != 7);
			// long receiver hold-off while items keep coming back to back
			if (p == 3)
				rx_hold_cycles = 150;
			for (int k = 0; k < 50; k++) begin
				if (p == 5 && k == 25)
					drain_results(4000);
				op = pick_op(grow);
				offer_item(op, pick_value(op), (p == 3) ? 0 : pick_gap(tx_idle));
			end
		end

		@(negedge clk);
		in_valid  = 1'b0;
		rx_random = 1'b0;
		drain_results(4000);
		repeat (8) @(negedge clk);
		if (shadow.awaited.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", shadow.awaited.size()));
		if (fail_count == 0)
			$display("** sorted_list_engine_core: PASSED **");
		else
			$display("** sorted_list_engine_core: FAILED **");
		$finish;
	end

endmodule
